FILE: src/pba_pkg.sv
package pba_pkg;

  localparam int PORT_W            = 16;
  localparam int STATUS_W          = 2;
  localparam int DEF_PORT_COUNT    = 65536;
  localparam int DEF_MAP_WORD_BITS = 64;
  localparam int CFG_ADDR_W        = 3;
  localparam int CFG_DATA_W        = 32;

  localparam logic [PORT_W-1:0] RESERVED_LIMIT_RST = 16'd1024;

  // register index within the configuration space (paddr[2])
  localparam logic REG_RESERVED_LIMIT = 1'b0;

  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_IN_USE      = 2'd2,
    ST_BAD_RELEASE = 2'd3
  } status_t;

endpackage

FILE: src/port_bitmap_allocator.sv
// explicit allocate or release: probe state, then finish state loads the result (a refused
// item skips probe); automatic search: one map word read per cycle over
// DEPTH = PORT_COUNT / MAP_WORD_BITS words plus a final revisit of the start word
// one item in flight at a time; the next input is taken while a result waits
// reset: synchronous; a clearing pass over all DEPTH words (1024 by default) writes
// the map with only port 0 taken, no input transfer is accepted meanwhile
module port_bitmap_allocator #(
  parameter int PORT_COUNT    = pba_pkg::DEF_PORT_COUNT,
  parameter int MAP_WORD_BITS = pba_pkg::DEF_MAP_WORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  // input item stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // port, search_start
  input  logic [0:0]                       s_axis_tuser,  // action
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // granted_port
  output logic [1:0]                       m_axis_tuser,  // status
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pba_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pba_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pba_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import pba_pkg::*;

  logic [PORT_W-1:0] reserved_limit;
  logic              reg_sel;
  logic              cfg_write;
  status_t           out_status;

  // register index is the word address
  assign reg_sel   = paddr[2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_limit <= RESERVED_LIMIT_RST;
    end else if (cfg_write && reg_sel == REG_RESERVED_LIMIT) begin
      reserved_limit <= pwdata[PORT_W-1:0];
    end
  end

  // writes beyond the register list are dropped and read back as zero
  assign prdata = (reg_sel == REG_RESERVED_LIMIT) ? CFG_DATA_W'(reserved_limit) : '0;

  // sequencer with the allocation map memory and the result register
  pba_ctrl #(
    .PORT_COUNT    (PORT_COUNT),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_action  (s_axis_tuser[0]),
    .in_port    (s_axis_tdata[15:0]),
    .in_start   (s_axis_tdata[31:16]),
    .limit      (reserved_limit),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_port   (m_axis_tdata),
    .out_status (out_status)
  );

  assign m_axis_tuser = out_status;

endmodule

FILE: src/pba_word_scan.sv
module pba_word_scan #(
  parameter int WORD_BITS = pba_pkg::DEF_MAP_WORD_BITS,
  parameter int ADDR_W    = 10
) (
  input  logic [WORD_BITS-1:0]         word,
  input  logic [ADDR_W-1:0]            word_addr,
  input  logic                         first,
  input  logic                         last,
  input  logic [$clog2(WORD_BITS)-1:0] start_bit,
  input  logic [pba_pkg::PORT_W-1:0]   limit,
  output logic                         hit,
  output logic [$clog2(WORD_BITS)-1:0] bit_idx
);
  import pba_pkg::*;

  localparam int S   = $clog2(WORD_BITS);
  localparam int LW_W = PORT_W - S;

  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] range_m;
  logic [WORD_BITS-1:0] limit_m;
  logic [WORD_BITS-1:0] zero_m;
  logic [WORD_BITS-1:0] free;
  logic [WORD_BITS-1:0] low;
  logic [LW_W-1:0]      lw;
  logic [S-1:0]         lb;
  logic [LW_W-1:0]      wext;

  assign ones = {WORD_BITS{1'b1}};
  assign lw   = limit[PORT_W-1:S];
  assign lb   = limit[S-1:0];
  assign wext = LW_W'(word_addr);

  always_comb begin
    // first word of the sweep covers the start bit upward, the final revisit the rest
    priority if (first) begin
      range_m = ones << start_bit;
    end else if (last) begin
      range_m = ~(ones << start_bit);
    end else begin
      range_m = ones;
    end

    // only ports above the reserved limit
    priority if (wext > lw) begin
      limit_m = ones;
    end else if (wext == lw) begin
      limit_m = (ones << lb) << 1;
    end else begin
      limit_m = '0;
    end

    zero_m = (word_addr == '0) ? ~WORD_BITS'(1) : ones;
    free   = ~word & range_m & limit_m & zero_m;
    low    = free & (~free + WORD_BITS'(1));

    bit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low[i]) begin
        bit_idx = bit_idx | S'(i);
      end
    end
    hit = |free;
  end

endmodule

FILE: src/pba_ctrl.sv
module pba_ctrl #(
  parameter int PORT_COUNT    = pba_pkg::DEF_PORT_COUNT,
  parameter int MAP_WORD_BITS = pba_pkg::DEF_MAP_WORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [pba_pkg::PORT_W-1:0]  in_port,
  input  logic [pba_pkg::PORT_W-1:0]  in_start,
  input  logic [pba_pkg::PORT_W-1:0]  limit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pba_pkg::PORT_W-1:0]  out_port,
  output pba_pkg::status_t            out_status
);
  import pba_pkg::*;

  localparam int S         = $clog2(MAP_WORD_BITS);
  localparam int DEPTH     = PORT_COUNT / MAP_WORD_BITS;
  localparam int DW        = $clog2(DEPTH);
  localparam int PORT_BITS = $clog2(PORT_COUNT);
  localparam logic [PORT_W:0] PORT_LIMIT = (PORT_W+1)'(PORT_COUNT);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t                   state;
  logic [DW-1:0]            clr_cnt;
  logic [DW:0]              scan_cnt;
  logic [DW-1:0]            data_addr;
  logic [S-1:0]             start_bit;
  logic                     action_q;
  logic [PORT_W-1:0]        port_q;
  logic [PORT_W-1:0]        res_port;
  status_t                  res_status;

  logic [MAP_WORD_BITS-1:0] mem [DEPTH];
  logic [MAP_WORD_BITS-1:0] rd_data;
  logic [DW-1:0]            rd_addr;
  logic                     wr_en;
  logic [DW-1:0]            wr_addr;
  logic [MAP_WORD_BITS-1:0] wr_data;

  logic                     in_range;
  logic                     in_search;
  logic [DW-1:0]            in_word;
  logic [DW-1:0]            start_word;
  logic [DW-1:0]            port_word;
  logic [S-1:0]             port_bit;
  logic [MAP_WORD_BITS-1:0] port_mask;
  logic                     hit;
  logic [S-1:0]             hit_idx;

  assign in_ready   = (state == S_IDLE);
  assign in_range   = {1'b0, in_port} < PORT_LIMIT;
  assign in_search  = (in_action == ACT_ALLOC) && (in_port == '0);
  assign in_word    = in_port[PORT_BITS-1:S];
  assign start_word = in_start[PORT_BITS-1:S];
  assign port_word  = port_q[PORT_BITS-1:S];
  assign port_bit   = port_q[S-1:0];
  assign port_mask  = MAP_WORD_BITS'(1) << port_bit;

  pba_word_scan #(
    .WORD_BITS (MAP_WORD_BITS),
    .ADDR_W    (DW)
  ) u_scan (
    .word      (rd_data),
    .word_addr (data_addr),
    .first     (scan_cnt == '0),
    .last      (scan_cnt == (DW+1)'(DEPTH)),
    .start_bit (start_bit),
    .limit     (limit),
    .hit       (hit),
    .bit_idx   (hit_idx)
  );

  // read address: next word of the sweep, or the word of an incoming item
  always_comb begin
    if (state == S_SEARCH) begin
      rd_addr = data_addr + DW'(1);
    end else if (in_search) begin
      rd_addr = start_word;
    end else begin
      rd_addr = in_word;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = data_addr;
    wr_data = rd_data;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = (clr_cnt == '0) ? MAP_WORD_BITS'(1) : '0;
      end
      S_PROBE: begin
        wr_addr = port_word;
        if (action_q == ACT_RELEASE) begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~port_mask;
        end else if ((rd_data & port_mask) == '0) begin
          wr_en   = 1'b1;
          wr_data = rd_data | port_mask;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          wr_en   = 1'b1;
          wr_data = rd_data | (MAP_WORD_BITS'(1) << hit_idx);
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // the finish state reloads the result register itself
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + DW'(1);
          if (clr_cnt == DW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            action_q   <= in_action;
            port_q     <= in_port;
            data_addr  <= start_word;
            start_bit  <= in_start[S-1:0];
            scan_cnt   <= '0;
            res_port   <= '0;
            res_status <= ST_OK;
            priority if (in_action == ACT_RELEASE && in_port == '0) begin
              res_status <= ST_BAD_RELEASE;
              state      <= S_FINISH;
            end else if (!in_range) begin
              res_status <= (in_action == ACT_RELEASE) ? ST_OK : ST_IN_USE;
              state      <= S_FINISH;
            end else if (in_search) begin
              state <= S_SEARCH;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          priority if (action_q == ACT_RELEASE) begin
            res_status <= ST_OK;
          end else if ((rd_data & port_mask) != '0) begin
            res_status <= ST_IN_USE;
          end else begin
            res_status <= ST_OK;
            res_port   <= port_q;
          end
          state <= S_FINISH;
        end
        S_SEARCH: begin
          priority if (hit) begin
            res_status <= ST_OK;
            res_port   <= PORT_W'({data_addr, hit_idx});
            state      <= S_FINISH;
          end else if (scan_cnt == (DW+1)'(DEPTH)) begin
            res_status <= ST_EXHAUSTED;
            state      <= S_FINISH;
          end else begin
            data_addr <= data_addr + DW'(1);
            scan_cnt  <= scan_cnt + (DW+1)'(1);
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            out_port   <= res_port;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/pba_checker.sv
module pba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);
  import pba_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a failed status never carries a port
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("nonzero port with failing status");

  // map clearing pass blocks input right after reset
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_axis_tready)
    else $error("input taken during map clear");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  // reserved limit reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[2] == REG_RESERVED_LIMIT) ##1
      (psel && !pwrite && (paddr[2] == REG_RESERVED_LIMIT) && !$past(rst)) |->
      (prdata == {16'd0, $past(pwdata[15:0])}))
    else $error("reserved limit read back mismatch");

endmodule

bind port_bitmap_allocator pba_checker u_pba_checker (.*);

FILE: dv/port_bitmap_allocator_tb.sv
`timescale 1ns / 100ps

module port_bitmap_allocator_tb;
  import pba_pkg::*;

  localparam int PORT_COUNT  = DEF_PORT_COUNT;
  localparam int STUCK_LIMIT = 10000;  // reset clearing pass, long searches, long stall
  localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = CFG_ADDR_W'(REG_RESERVED_LIMIT) << 2;

  // one expected result per accepted item
  typedef struct packed {
    logic [PORT_W-1:0] granted;
    status_t           status;
  } grant_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata = '0;   // port, search_start
  logic [0:0]            s_axis_tuser = '0;   // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;        // granted_port
  logic [1:0]            m_axis_tuser;        // status
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow of the allocation map and the search floor
  bit                    port_taken [PORT_COUNT];
  logic [PORT_W-1:0]     reserved_limit_q = RESERVED_LIMIT_RST;

  grant_t                pending_grants [$];
  logic [PORT_W-1:0]     held_ports [$];    // ports the stimulus believes are allocated
  grant_t                oldest_grant;
  int                    mismatches = 0;
  int                    stuck_cycles = 0;
  int                    tx_calm_left = 0;  // items left in a no-gap burst on the input side
  int                    rx_calm_left = 0;  // results left in a no-stall burst on the output side
  int                    rx_hold_cycles = 0;

  port_bitmap_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk = ~clk;

  initial begin
    port_taken[0] = 1'b1;  // port 0 is held for good
  end

  // expected outcome of one item, updating the shadow map as the block would
  function automatic void predict_grant(input action_t act, input logic [PORT_W-1:0] port,
                                        input logic [PORT_W-1:0] start,
                                        output grant_t outcome);
    int unsigned cand;
    int unsigned tries;
    outcome.granted = '0;
    outcome.status  = ST_OK;
    if (act == ACT_RELEASE) begin
      // releasing a free port is harmless; port 0 is refused
      if (port == 0) outcome.status = ST_BAD_RELEASE;
      else port_taken[port] = 1'b0;
    end else if (port == 0) begin
      // upward search with wraparound; the port just below start is the last one tried
      cand  = start;
      tries = 0;
      while (outcome.granted == 0 && tries < PORT_COUNT) begin
        if (cand != 0 && cand > reserved_limit_q && !port_taken[cand])
          outcome.granted = cand[PORT_W-1:0];
        cand = (cand + 1) % PORT_COUNT;
        tries++;
      end
      if (outcome.granted == 0) outcome.status = ST_EXHAUSTED;
      else port_taken[outcome.granted] = 1'b1;
    end else if (port_taken[port]) begin
      outcome.status = ST_IN_USE;
    end else begin
      port_taken[port] = 1'b1;
      outcome.granted  = port;
    end
  endfunction

  // one input transfer after a random gap; valid stays high for a back-to-back item
  task automatic send_item(input action_t act, input logic [PORT_W-1:0] port,
                           input logic [PORT_W-1:0] start);
    int     gap;
    grant_t outcome;
    gap = 0;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
    end else begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 15) == 0) tx_calm_left = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {start, port};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    predict_grant(act, port, start, outcome);
    pending_grants.push_back(outcome);
    if (outcome.status == ST_OK && outcome.granted != 0) held_ports.push_back(outcome.granted);
  endtask

  // input goes quiet until every result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // setup and access phase; psel is left high for a following transfer
  task automatic apb_transfer(input bit wr, input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LIMIT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  // read back the current limit, write the new one, read it back again
  task automatic program_limit(input logic [PORT_W-1:0] value);
    logic [CFG_DATA_W-1:0] rdata;
    logic [CFG_DATA_W-1:0] ignored;
    wait_drained();
    apb_transfer(1'b0, '0, rdata);
    if (rdata !== CFG_DATA_W'(reserved_limit_q)) begin
      $display("%0t: reserved_limit read expected %0d actual %0d",
               $time, reserved_limit_q, rdata);
      mismatches++;
    end
    apb_transfer(1'b1, CFG_DATA_W'(value), ignored);
    reserved_limit_q = value;
    apb_transfer(1'b0, '0, rdata);
    if (rdata !== CFG_DATA_W'(value)) begin
      $display("%0t: reserved_limit read expected %0d actual %0d", $time, value, rdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // explicit claims and releases at the default limit, field extremes included
  task automatic test_explicit_ports();
    send_item(ACT_ALLOC,   16'd1,      16'h0000);
    send_item(ACT_ALLOC,   16'd1,      16'hffff);  // already taken
    send_item(ACT_ALLOC,   16'hffff,   16'h5555);
    send_item(ACT_ALLOC,   16'haaaa,   16'haaaa);
    send_item(ACT_ALLOC,   16'h5555,   16'h1234);
    send_item(ACT_ALLOC,   16'd1024,   16'($urandom));  // explicit claims ignore the limit
    send_item(ACT_RELEASE, 16'd0,      16'($urandom));  // port 0 cannot be released
    send_item(ACT_RELEASE, 16'd1,      16'($urandom));
    send_item(ACT_RELEASE, 16'd1,      16'($urandom));  // already free
    send_item(ACT_RELEASE, 16'hffff,   16'($urandom));
  endtask

  // automatic search at the default limit: skipping below the floor and wrapping
  task automatic test_search_wrap();
    send_item(ACT_ALLOC, 16'd0, 16'd0);
    send_item(ACT_ALLOC, 16'd0, 16'hffff);
    send_item(ACT_ALLOC, 16'd0, 16'd1024);
    send_item(ACT_ALLOC, 16'd0, 16'h8000);
  endtask

  // tiny pool at the top: fill it, exhaust it, then find the port just below start
  task automatic test_search_exhaust();
    program_limit(16'd65532);
    send_item(ACT_ALLOC,   16'd0,     16'd0);
    send_item(ACT_ALLOC,   16'd0,     16'd65534);
    send_item(ACT_ALLOC,   16'd0,     16'd0);
    send_item(ACT_ALLOC,   16'd0,     16'h1234);     // nothing free
    send_item(ACT_RELEASE, 16'd65534, 16'($urandom));
    send_item(ACT_ALLOC,   16'd0,     16'hffff);     // only free candidate is start - 1
    send_item(ACT_RELEASE, 16'd65533, 16'($urandom));
  endtask

  // limit at both ends: port 0 never granted, everything skipped
  task automatic test_limit_extremes();
    program_limit(16'd0);
    send_item(ACT_ALLOC, 16'd0, 16'd0);
    send_item(ACT_ALLOC, 16'd0, 16'hffff);
    program_limit(16'hffff);
    send_item(ACT_ALLOC, 16'd0, 16'h7fff);
    send_item(ACT_ALLOC, 16'd2, 16'($urandom));
  endtask

  // receiver stalls for a long stretch while the input keeps coming
  task automatic test_result_backpressure();
    program_limit(RESERVED_LIMIT_RST);
    rx_hold_cycles = 300;
    tx_calm_left   = 16;
    repeat (16) begin
      if ($urandom_range(0, 1) == 0) send_item(ACT_ALLOC, 16'd0, 16'($urandom));
      else send_item(ACT_ALLOC, 16'($urandom_range(1, 65535)), 16'($urandom));
    end
    wait_drained();
  endtask

  // mostly well-formed traffic: searches, claims of held ports, releases of held ports
  task automatic run_mixed(input int count);
    int                pick;
    int                idx;
    logic [PORT_W-1:0] p;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 39) == 0) wait_drained();
      if (pick < 42) begin
        send_item(ACT_ALLOC, 16'd0, 16'($urandom));
      end else if (pick < 56) begin
        send_item(ACT_ALLOC, 16'($urandom_range(1, 65535)), 16'($urandom));
      end else if (pick < 64 && held_ports.size() > 0) begin
        idx = $urandom_range(0, held_ports.size() - 1);
        send_item(ACT_ALLOC, held_ports[idx], 16'($urandom));
      end else if (pick < 90 && held_ports.size() > 0) begin
        idx = $urandom_range(0, held_ports.size() - 1);
        p   = held_ports[idx];
        held_ports.delete(idx);
        send_item(ACT_RELEASE, p, 16'($urandom));
      end else if (pick < 97) begin
        send_item(ACT_RELEASE, 16'($urandom_range(1, 65535)), 16'($urandom));
      end else begin
        send_item(ACT_RELEASE, 16'd0, 16'($urandom));
      end
    end
  endtask

  // random traffic under several limits; a small top pool runs dry often
  task automatic test_mixed_traffic();
    program_limit(16'd65500);
    run_mixed(120);
    program_limit(16'd0);
    run_mixed(110);
    program_limit(16'($urandom_range(1, 65534)));
    run_mixed(140);
    program_limit(RESERVED_LIMIT_RST);
    run_mixed(150);
    program_limit(16'hffff);  // every search comes back exhausted
    run_mixed(15);
  endtask

  // result side: random stall per result, bursts without stalls, one long hold on request
  initial begin : result_sink
    int stall;
    forever begin
      stall = 0;
      if (rx_hold_cycles > 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else if (rx_calm_left > 0) begin
        rx_calm_left--;
      end else begin
        stall = $urandom_range(0, 11);
        if ($urandom_range(0, 15) == 0) rx_calm_left = $urandom_range(8, 30);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result expected none actual granted_port=%0d status=%0d",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        oldest_grant = pending_grants.pop_front();
        if (m_axis_tdata !== oldest_grant.granted) begin
          $display("%0t: granted_port expected %0d actual %0d",
                   $time, oldest_grant.granted, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser !== oldest_grant.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, oldest_grant.status, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on either stream
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
      $display("port_bitmap_allocator regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_explicit_ports();
    test_search_wrap();
    test_search_exhaust();
    test_limit_extremes();
    test_result_backpressure();
    test_mixed_traffic();
    wait_drained();
    repeat (20) @(posedge clk);  // any stray result would show up here
    if (mismatches == 0)
      $display("port_bitmap_allocator regression: pass");
    else
      $display("port_bitmap_allocator regression: fail");
    $finish;
  end

endmodule
